// ----- design/word_sbox_lehmer_stream_cipher_assert.svh -----
// Assertion macros shared by the cipher modules.
`ifndef WORD_SBOX_LEHMER_STREAM_CIPHER_ASSERT_SVH
`define WORD_SBOX_LEHMER_STREAM_CIPHER_ASSERT_SVH

// Checked only outside reset.
`define WSLSC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every edge, reset included.
`define WSLSC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- design/wslsc_pkg.sv -----
package wslsc_pkg;

  typedef enum logic {
    ACT_DECRYPT = 1'b0,
    ACT_ENCRYPT = 1'b1
  } action_t;

  // Control from the pipeline to the key generator.
  typedef struct packed {
    logic step;
    logic restart;
  } key_ctrl_t;

  localparam logic [13:0] HI_MULT    = 14'h2345;
  localparam logic [14:0] LO_MULT    = 15'h7f8d;
  localparam logic [15:0] HI_MOD     = 16'hffd9;
  localparam logic [15:0] LO_MOD     = 16'hfff1;
  localparam logic [15:0] HI_DEFAULT = 16'h2345;
  localparam logic [15:0] LO_DEFAULT = 16'h7f8d;
  // 2^16 mod HI_MOD and 2^16 mod LO_MOD.
  localparam logic [5:0]  HI_FOLD    = 6'd39;
  localparam logic [3:0]  LO_FOLD    = 4'd15;

  // high = high * 0x2345 mod 0xffd9, folding the upper half twice.
  function automatic logic [15:0] hi_advance(input logic [15:0] k);
    logic [29:0] prod;
    logic [19:0] f1;
    logic [16:0] f2;
    prod = 30'(k) * 30'(HI_MULT);
    f1 = 20'(prod[29:16]) * 20'(HI_FOLD) + 20'(prod[15:0]);
    f2 = 17'(f1[19:16]) * 17'(HI_FOLD) + 17'(f1[15:0]);
    return (f2 >= 17'(HI_MOD)) ? 16'(f2 - 17'(HI_MOD)) : f2[15:0];
  endfunction

  // low = low * 0x7f8d mod 0xfff1, same folding scheme.
  function automatic logic [15:0] lo_advance(input logic [15:0] k);
    logic [30:0] prod;
    logic [19:0] f1;
    logic [16:0] f2;
    prod = 31'(k) * 31'(LO_MULT);
    f1 = 20'(prod[30:16]) * 20'(LO_FOLD) + 20'(prod[15:0]);
    f2 = 17'(f1[19:16]) * 17'(LO_FOLD) + 17'(f1[15:0]);
    return (f2 >= 17'(LO_MOD)) ? 16'(f2 - 17'(LO_MOD)) : f2[15:0];
  endfunction

  localparam logic [7:0] DEC_SBOX [256] = '{
    8'hcb, 8'h96, 8'h85, 8'ha6, 8'h5f, 8'h3e, 8'hab, 8'h03,
    8'h50, 8'hb7, 8'h9c, 8'h5c, 8'hb2, 8'h40, 8'hef, 8'hf6,
    8'hff, 8'h61, 8'h15, 8'h29, 8'ha2, 8'hf1, 8'hec, 8'h52,
    8'h35, 8'h28, 8'hd9, 8'h68, 8'h24, 8'h36, 8'hc4, 8'h74,
    8'h26, 8'he2, 8'hd5, 8'h8c, 8'h47, 8'h4d, 8'h2c, 8'hfa,
    8'h86, 8'h66, 8'hc1, 8'h4f, 8'h0b, 8'h81, 8'h5b, 8'h1b,
    8'hc0, 8'h0a, 8'hfd, 8'h17, 8'ha4, 8'ha9, 8'h6d, 8'h63,
    8'had, 8'hf3, 8'hf4, 8'h6e, 8'h8d, 8'h89, 8'h14, 8'hdd,
    8'h59, 8'h87, 8'h4a, 8'h30, 8'hce, 8'hfe, 8'h3f, 8'h7e,
    8'h06, 8'h49, 8'ha5, 8'h04, 8'h5e, 8'hd0, 8'hde, 8'he8,
    8'h0f, 8'hd4, 8'h13, 8'h1f, 8'hba, 8'hb9, 8'h69, 8'h71,
    8'h3d, 8'he4, 8'hdc, 8'h58, 8'h90, 8'h34, 8'h3a, 8'h3c,
    8'hca, 8'h10, 8'h76, 8'hc7, 8'hc8, 8'h45, 8'h33, 8'hc3,
    8'h92, 8'h1d, 8'h2b, 8'h1c, 8'h8f, 8'h6f, 8'h05, 8'h07,
    8'h38, 8'h57, 8'h51, 8'hd6, 8'hda, 8'h2d, 8'hb3, 8'hc6,
    8'h2e, 8'h64, 8'h32, 8'h1e, 8'h43, 8'hb1, 8'h5d, 8'he1,
    8'hbb, 8'h8e, 8'h9d, 8'h72, 8'h77, 8'hf2, 8'h27, 8'hc9,
    8'h7f, 8'h9e, 8'haa, 8'h6a, 8'h2f, 8'h6c, 8'hf9, 8'h48,
    8'he7, 8'ha0, 8'h09, 8'h56, 8'hb8, 8'hbd, 8'h20, 8'h41,
    8'hcd, 8'h95, 8'h80, 8'hd7, 8'h23, 8'h0c, 8'h42, 8'he5,
    8'hae, 8'h8b, 8'h7d, 8'hbc, 8'h54, 8'h39, 8'hbf, 8'h65,
    8'h01, 8'h88, 8'he0, 8'h7b, 8'hb6, 8'h16, 8'h18, 8'h4b,
    8'hcc, 8'h22, 8'h5a, 8'hb5, 8'heb, 8'hfc, 8'hf8, 8'h9b,
    8'h4e, 8'he6, 8'ha8, 8'hbe, 8'h67, 8'h73, 8'h97, 8'h94,
    8'h00, 8'h62, 8'hb4, 8'hd2, 8'h21, 8'h25, 8'h11, 8'h82,
    8'hdb, 8'h93, 8'h02, 8'h84, 8'h7c, 8'hd3, 8'hb0, 8'ha3,
    8'h91, 8'ha7, 8'hf7, 8'h55, 8'h70, 8'h7a, 8'h08, 8'h75,
    8'h8a, 8'h53, 8'h79, 8'hfb, 8'h9f, 8'h46, 8'hf5, 8'h83,
    8'hd8, 8'h0e, 8'he9, 8'hed, 8'h12, 8'hd1, 8'hdf, 8'hf0,
    8'h37, 8'h2a, 8'h44, 8'h19, 8'h9a, 8'h31, 8'hcf, 8'ha1,
    8'haf, 8'he3, 8'h3b, 8'h1a, 8'h4c, 8'h78, 8'hc2, 8'h60,
    8'hee, 8'h98, 8'h6b, 8'h0d, 8'h99, 8'hea, 8'hc5, 8'hac
  };

  localparam logic [7:0] ENC_SBOX [256] = '{
    8'hc0, 8'ha8, 8'hca, 8'h07, 8'h4b, 8'h6e, 8'h48, 8'h6f,
    8'hd6, 8'h92, 8'h31, 8'h2c, 8'h9d, 8'hfb, 8'he1, 8'h50,
    8'h61, 8'hc6, 8'he4, 8'h52, 8'h3e, 8'h12, 8'had, 8'h33,
    8'hae, 8'heb, 8'hf3, 8'h2f, 8'h6b, 8'h69, 8'h7b, 8'h53,
    8'h96, 8'hc4, 8'hb1, 8'h9c, 8'h1c, 8'hc5, 8'h20, 8'h86,
    8'h19, 8'h13, 8'he9, 8'h6a, 8'h26, 8'h75, 8'h78, 8'h8c,
    8'h43, 8'hed, 8'h7a, 8'h66, 8'h5d, 8'h18, 8'h1d, 8'he8,
    8'h70, 8'ha5, 8'h5e, 8'hf2, 8'h5f, 8'h58, 8'h05, 8'h46,
    8'h0d, 8'h97, 8'h9e, 8'h7c, 8'hea, 8'h65, 8'hdd, 8'h24,
    8'h8f, 8'h49, 8'h42, 8'haf, 8'hf4, 8'h25, 8'hb8, 8'h2b,
    8'h08, 8'h72, 8'h17, 8'hd9, 8'ha4, 8'hd3, 8'h93, 8'h71,
    8'h5b, 8'h40, 8'hb2, 8'h2e, 8'h0b, 8'h7e, 8'h4c, 8'h04,
    8'hf7, 8'h11, 8'hc1, 8'h37, 8'h79, 8'ha7, 8'h29, 8'hbc,
    8'h1b, 8'h56, 8'h8b, 8'hfa, 8'h8d, 8'h36, 8'h3b, 8'h6d,
    8'hd4, 8'h57, 8'h83, 8'hbd, 8'h1f, 8'hd7, 8'h62, 8'h84,
    8'hf5, 8'hda, 8'hd5, 8'hab, 8'hcc, 8'ha2, 8'h47, 8'h88,
    8'h9a, 8'h2d, 8'hc7, 8'hdf, 8'hcb, 8'h02, 8'h28, 8'h41,
    8'ha9, 8'h3d, 8'hd8, 8'ha1, 8'h23, 8'h3c, 8'h81, 8'h6c,
    8'h5c, 8'hd0, 8'h68, 8'hc9, 8'hbf, 8'h99, 8'h01, 8'hbe,
    8'hf9, 8'hfc, 8'hec, 8'hb7, 8'h0a, 8'h82, 8'h89, 8'hdc,
    8'h91, 8'hef, 8'h14, 8'hcf, 8'h34, 8'h4a, 8'h03, 8'hd1,
    8'hba, 8'h35, 8'h8a, 8'h06, 8'hff, 8'h38, 8'ha0, 8'hf0,
    8'hce, 8'h7d, 8'h0c, 8'h76, 8'hc2, 8'hb3, 8'hac, 8'h09,
    8'h94, 8'h55, 8'h54, 8'h80, 8'ha3, 8'h95, 8'hbb, 8'ha6,
    8'h30, 8'h2a, 8'hf6, 8'h67, 8'h1e, 8'hfe, 8'h77, 8'h63,
    8'h64, 8'h87, 8'h60, 8'h00, 8'hb0, 8'h98, 8'h44, 8'hee,
    8'h4d, 8'he5, 8'hc3, 8'hcd, 8'h51, 8'h22, 8'h73, 8'h9b,
    8'he0, 8'h1a, 8'h74, 8'hc8, 8'h5a, 8'h3f, 8'h4e, 8'he6,
    8'haa, 8'h7f, 8'h21, 8'hf1, 8'h59, 8'h9f, 8'hb9, 8'h90,
    8'h4f, 8'he2, 8'hfd, 8'hb4, 8'h16, 8'he3, 8'hf8, 8'h0e,
    8'he7, 8'h15, 8'h85, 8'h39, 8'h3a, 8'hde, 8'h0f, 8'hd2,
    8'hb6, 8'h8e, 8'h27, 8'hdb, 8'hb5, 8'h32, 8'h45, 8'h10
  };

endpackage

// ----- design/wslsc_keygen.sv -----
`include "word_sbox_lehmer_stream_cipher_assert.svh"

module wslsc_keygen
  import wslsc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        seed_wr_en,
  input  logic [31:0] seed_wr_data,
  input  key_ctrl_t   ctrl,
  output logic [31:0] keystream
);

  logic [31:0] seed;
  logic [15:0] key_high;
  logic [15:0] key_low;
  logic [15:0] base_high;
  logic [15:0] base_low;
  logic [15:0] key_high_next;
  logic [15:0] key_low_next;

  // On a restart the halves reload from the seed, with a zero half taking its default.
  always_comb begin
    if (ctrl.restart) begin
      base_high = (seed[31:16] == 16'h0) ? HI_DEFAULT : seed[31:16];
      base_low  = (seed[15:0] == 16'h0) ? LO_DEFAULT : seed[15:0];
    end else begin
      base_high = key_high;
      base_low  = key_low;
    end
    key_high_next = hi_advance(base_high);
    key_low_next  = lo_advance(base_low);
  end

  assign keystream = {key_high_next, key_low_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      seed     <= 32'h0;
      key_high <= HI_DEFAULT;
      key_low  <= LO_DEFAULT;
    end else begin
      if (seed_wr_en) begin
        seed <= seed_wr_data;
      end
      if (ctrl.step) begin
        key_high <= key_high_next;
        key_low  <= key_low_next;
      end
    end
  end

  `WSLSC_ASSERT(a_key_hold, !ctrl.step |=> $stable(key_high) && $stable(key_low), "key moved without a step")
  `WSLSC_ASSERT(a_key_reduced, ctrl.step |=> (key_high < HI_MOD) && (key_low < LO_MOD), "advanced key not reduced")
  `WSLSC_ASSERT_ALWAYS(a_key_reset, rst |=> (key_high == HI_DEFAULT) && (key_low == LO_DEFAULT), "key not at default after reset")

endmodule

// ----- design/wslsc_xform.sv -----
module wslsc_xform
  import wslsc_pkg::*;
(
  input  logic        action,
  input  logic [31:0] word,
  input  logic [31:0] keystream,
  output logic [31:0] result
);

  logic [31:0] mixed;
  logic [31:0] enc_sub;
  logic [31:0] dec_sub;

  // Encryption substitutes after the XOR, decryption before it.
  always_comb begin
    mixed = word ^ keystream;
    for (int i = 0; i < 4; i++) begin
      enc_sub[8*i +: 8] = ENC_SBOX[mixed[8*i +: 8]];
      dec_sub[8*i +: 8] = DEC_SBOX[word[8*i +: 8]];
    end
    result = (action == ACT_ENCRYPT) ? enc_sub : (dec_sub ^ keystream);
  end

endmodule

// ----- design/word_sbox_lehmer_stream_cipher.sv -----
// Word stream cipher with byte substitution and a two-part Lehmer keystream. Each request
// carries one 32-bit word, an action (0 decrypt, 1 encrypt) and a restart flag; every request
// yields exactly one result word, in order. Before each word both 16-bit key halves advance
// (high = high * 0x2345 mod 0xffd9, low = low * 0x7f8d mod 0xfff1) and the keystream is
// {high, low}. A restart first reloads the halves from the seed register (bits 31:16 high,
// bits 15:0 low, a zero half loading 0x2345 or 0x7f8d), so the first word after a restart
// already uses the advanced seed. Write the seed only while no request is in flight. The
// block takes one word per clock cycle while the result side does not stall. A request passes
// through the input register and then the result register before its result appears on
// word_out. The key update (a constant multiply and modular fold) and the word transform
// both sit in the combinational logic between those two registers. A stalled result
// holds the request in the input register, and new requests stall only once both
// registers are full.
`include "word_sbox_lehmer_stream_cipher_assert.svh"

module word_sbox_lehmer_stream_cipher
  import wslsc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        seed_wr_en,
  input  logic [31:0] seed_wr_data,
  input  logic        data_valid,
  output logic        data_stall,
  input  logic        action,
  input  logic        restart,
  input  logic [31:0] word_in,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [31:0] word_out
);

  // Input register: holds the accepted request until the result register can take it.
  logic        in_q_valid;
  logic        action_q;
  logic        restart_q;
  logic [31:0] word_q;

  logic        advance;
  logic        accept;
  logic [31:0] keystream;
  logic [31:0] result_next;
  key_ctrl_t   key_ctrl;

  // The held request moves on whenever the result register is empty or being drained.
  // A new request is taken whenever the input register is empty or moving on in the
  // same cycle, so a single waiting result does not stall the input side.
  assign advance    = in_q_valid && (!result_valid || !result_stall);
  assign data_stall = in_q_valid && !advance;
  assign accept     = data_valid && !data_stall;

  // The key steps exactly once for every request that reaches the result register.
  assign key_ctrl.step    = advance;
  assign key_ctrl.restart = restart_q;

  wslsc_keygen u_keygen (
    .clk          (clk),
    .rst          (rst),
    .seed_wr_en   (seed_wr_en),
    .seed_wr_data (seed_wr_data),
    .ctrl         (key_ctrl),
    .keystream    (keystream)
  );

  wslsc_xform u_xform (
    .action    (action_q),
    .word      (word_q),
    .keystream (keystream),
    .result    (result_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (accept) begin
      in_q_valid <= 1'b1;
    end else if (advance) begin
      in_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      action_q  <= action;
      restart_q <= restart;
      word_q    <= word_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      word_out <= result_next;
    end
  end

  `WSLSC_ASSERT(a_advance_gives_result, advance |=> result_valid, "advanced request produced no result")
  `WSLSC_ASSERT(a_stall_only_when_full, data_stall |-> in_q_valid && result_valid, "request stalled with room to spare")
  `WSLSC_ASSERT_ALWAYS(a_empty_after_reset, rst |=> !in_q_valid && !result_valid, "pipeline not empty after reset")

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
  import wslsc_pkg::*;

  // Key recurrence constants, kept locally so the expected words do not lean on the
  // arithmetic inside the block.
  localparam logic [31:0] KEY_HI_MULT  = 32'h2345;
  localparam logic [31:0] KEY_LO_MULT  = 32'h7f8d;
  localparam logic [31:0] KEY_HI_MOD   = 32'hffd9;
  localparam logic [31:0] KEY_LO_MOD   = 32'hfff1;
  localparam logic [15:0] KEY_HI_START = 16'h2345;
  localparam logic [15:0] KEY_LO_START = 16'h7f8d;

  // Byte substitution tables, entry 0 in the leftmost byte.
  localparam logic [0:255][7:0] UNMIX_BYTE = {
    128'hcb9685a65f3eab0350b79c5cb240eff6, 128'hff611529a2f1ec523528d9682436c474,
    128'h26e2d58c474d2cfa8666c14f0b815b1b, 128'hc00afd17a4a96d63adf3f46e8d8914dd,
    128'h59874a30cefe3f7e0649a5045ed0dee8, 128'h0fd4131fbab969713de4dc5890343a3c,
    128'hca1076c7c84533c3921d2b1c8f6f0507, 128'h385751d6da2db3c62e64321e43b15de1,
    128'hbb8e9d7277f227c97f9eaa6a2f6cf948, 128'he7a00956b8bd2041cd9580d7230c42e5,
    128'hae8b7dbc5439bf650188e07bb616184b, 128'hcc225ab5ebfcf89b4ee6a8be67739794,
    128'h0062b4d221251182db9302847cd3b0a3, 128'h91a7f755707a08758a5379fb9f46f583,
    128'hd80ee9ed12d1dff0372a44199a31cfa1, 128'hafe33b1a4c78c260ee986b0d99eac5ac
  };
  localparam logic [0:255][7:0] MIX_BYTE = {
    128'hc0a8ca074b6e486fd692312c9dfbe150, 128'h61c6e4523e12ad33aeebf32f6b697b53,
    128'h96c4b19c1cc520861913e96a2675788c, 128'h43ed7a665d181de870a55ef25f580546,
    128'h0d979e7cea65dd248f4942aff425b82b, 128'h087217d9a4d393715b40b22e0b7e4c04,
    128'hf711c13779a729bc1b568bfa8d363b6d, 128'hd45783bd1fd76284f5dad5abcca24788,
    128'h9a2dc7dfcb022841a93dd8a1233c816c, 128'h5cd068c9bf9901bef9fcecb70a8289dc,
    128'h91ef14cf344a03d1ba358a06ff38a0f0, 128'hce7d0c76c2b3ac0994555480a395bba6,
    128'h302af6671efe776364876000b09844ee, 128'h4de5c3cd5122739be01a74c85a3f4ee6,
    128'haa7f21f1599fb9904fe2fdb416e3f80e, 128'he71585393ade0fd2b68e27dbb5324510
  };

  // One row of the directed table: either a seed write or a request. For a request the
  // known flag marks rows whose result is typed in directly.
  typedef struct packed {
    logic        is_seed;
    logic [31:0] value;
    action_t     act;
    logic        reload;
    logic        known;
    logic [31:0] want;
  } row_t;

  localparam int DIRECTED_ROWS = 24;

  // A seed whose halves equal their moduli forces both key halves to zero after the
  // first step, so the keystream is zero and the results are plain table lookups.
  localparam row_t DIRECTED [DIRECTED_ROWS] = '{
    '{1'b0, 32'h0000_0000, ACT_DECRYPT, 1'b0, 1'b0, 32'h0},
    '{1'b0, 32'hffff_ffff, ACT_ENCRYPT, 1'b0, 1'b0, 32'h0},
    '{1'b0, 32'h1234_5678, ACT_DECRYPT, 1'b1, 1'b0, 32'h0},
    '{1'b1, 32'hffd9_fff1, ACT_DECRYPT, 1'b0, 1'b0, 32'h0},
    '{1'b0, 32'h0000_0000, ACT_DECRYPT, 1'b1, 1'b1, 32'hcbcb_cbcb},
    '{1'b0, 32'h0000_0000, ACT_ENCRYPT, 1'b0, 1'b1, 32'hc0c0_c0c0},
    '{1'b0, 32'hffff_ffff, ACT_DECRYPT, 1'b0, 1'b1, 32'hacac_acac},
    '{1'b0, 32'hffff_ffff, ACT_ENCRYPT, 1'b0, 1'b1, 32'h1010_1010},
    '{1'b0, 32'h0302_0100, ACT_ENCRYPT, 1'b0, 1'b1, 32'h07ca_a8c0},
    '{1'b1, 32'hffff_ffff, ACT_DECRYPT, 1'b0, 1'b0, 32'h0},
    '{1'b0, 32'ha5a5_a5a5, ACT_ENCRYPT, 1'b1, 1'b0, 32'h0},
    '{1'b0, 32'h5a5a_5a5a, ACT_DECRYPT, 1'b0, 1'b0, 32'h0},
    '{1'b1, 32'h0000_fff1, ACT_DECRYPT, 1'b0, 1'b0, 32'h0},
    '{1'b0, 32'h8000_0001, ACT_DECRYPT, 1'b1, 1'b0, 32'h0},
    '{1'b0, 32'h7fff_fffe, ACT_ENCRYPT, 1'b0, 1'b0, 32'h0},
    '{1'b1, 32'hffd9_0000, ACT_DECRYPT, 1'b0, 1'b0, 32'h0},
    '{1'b0, 32'h00ff_00ff, ACT_ENCRYPT, 1'b1, 1'b0, 32'h0},
    '{1'b1, 32'hffd8_fff0, ACT_DECRYPT, 1'b0, 1'b0, 32'h0},
    '{1'b0, 32'hdead_beef, ACT_DECRYPT, 1'b1, 1'b0, 32'h0},
    '{1'b0, 32'hcafe_f00d, ACT_ENCRYPT, 1'b1, 1'b0, 32'h0},
    '{1'b1, 32'hffda_fff2, ACT_DECRYPT, 1'b0, 1'b0, 32'h0},
    '{1'b0, 32'h0123_4567, ACT_DECRYPT, 1'b1, 1'b0, 32'h0},
    '{1'b0, 32'h89ab_cdef, ACT_ENCRYPT, 1'b0, 1'b0, 32'h0},
    '{1'b0, 32'h0f0f_f0f0, ACT_ENCRYPT, 1'b0, 1'b0, 32'h0}
  };

  localparam int PHASES          = 8;
  localparam int PHASE_REQUESTS  = 240;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        seed_wr_en = 1'b0;
  logic [31:0] seed_wr_data = '0;
  logic        data_valid = 1'b0;
  logic        data_stall;
  action_t     action = ACT_DECRYPT;
  logic        restart = 1'b0;
  logic [31:0] word_in = '0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  logic [31:0] word_out;

  // Typed-in result that travels with the request it belongs to.
  logic        known_valid = 1'b0;
  logic [31:0] known_word = '0;

  // Shadow of the block: seed register and both key halves.
  logic [31:0] seed_shadow;
  logic [15:0] key_hi;
  logic [15:0] key_lo;

  logic [31:0] expected_words [$];
  int          mismatch_count = 0;

  // Idle controls. The percentages give the chance that a stall burst starts at a given cycle
  // or a gap at a given request; calm switches all idling off for the final stretch of the run.
  int          gap_pct = 0;
  int          stall_pct = 0;
  bit          calm = 1'b0;

  word_sbox_lehmer_stream_cipher u_dut (
    .clk          (clk),
    .rst          (rst),
    .seed_wr_en   (seed_wr_en),
    .seed_wr_data (seed_wr_data),
    .data_valid   (data_valid),
    .data_stall   (data_stall),
    .action       (action),
    .restart      (restart),
    .word_in      (word_in),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .word_out     (word_out)
  );

  always #10 clk = ~clk;

  function automatic logic [15:0] lehmer_hi_next(input logic [15:0] k);
    logic [31:0] prod;
    prod = {16'd0, k} * KEY_HI_MULT;
    return 16'(prod % KEY_HI_MOD);
  endfunction

  function automatic logic [15:0] lehmer_lo_next(input logic [15:0] k);
    logic [31:0] prod;
    prod = {16'd0, k} * KEY_LO_MULT;
    return 16'(prod % KEY_LO_MOD);
  endfunction

  // Encryption whitens first and substitutes after; decryption does the reverse.
  function automatic logic [31:0] cipher_word(input action_t act, input logic [31:0] w,
                                              input logic [31:0] keystream);
    logic [31:0] mixed;
    logic [31:0] r;
    mixed = (act == ACT_ENCRYPT) ? (w ^ keystream) : w;
    for (int i = 0; i < 4; i++) begin
      if (act == ACT_ENCRYPT) begin
        r[8*i +: 8] = MIX_BYTE[mixed[8*i +: 8]];
      end else begin
        r[8*i +: 8] = UNMIX_BYTE[mixed[8*i +: 8]];
      end
    end
    return (act == ACT_ENCRYPT) ? r : (r ^ keystream);
  endfunction

  task automatic flag_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // Everything is sampled at the rising edge, before the block's own updates land. An
  // accepted request first reloads the keys if asked, then steps them, and only then
  // produces its expected word; an accepted result is matched with the oldest one.
  always @(posedge clk) begin
    logic [31:0] predicted;
    logic [31:0] oldest;
    if (rst) begin
      seed_shadow = '0;
      key_hi = KEY_HI_START;
      key_lo = KEY_LO_START;
    end else begin
      if (seed_wr_en) begin
        seed_shadow = seed_wr_data;
      end
      if (data_valid && !data_stall) begin
        if (restart) begin
          key_hi = (seed_shadow[31:16] == '0) ? KEY_HI_START : seed_shadow[31:16];
          key_lo = (seed_shadow[15:0] == '0) ? KEY_LO_START : seed_shadow[15:0];
        end
        key_hi = lehmer_hi_next(key_hi);
        key_lo = lehmer_lo_next(key_lo);
        predicted = cipher_word(action, word_in, {key_hi, key_lo});
        if (known_valid) begin
          predicted = known_word;
        end
        expected_words.push_back(predicted);
      end
      if (result_valid && !result_stall) begin
        if (expected_words.size() == 0) begin
          flag_mismatch($sformatf("result %h with no request waiting", word_out));
        end else begin
          oldest = expected_words.pop_front();
          if (word_out !== oldest) begin
            flag_mismatch($sformatf("word_out %h, expected %h", word_out, oldest));
          end
        end
      end
    end
  end

  // The result side holds off in random bursts whose frequency follows stall_pct.
  initial begin
    forever begin
      @(negedge clk);
      if (!calm && stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
        result_stall <= 1'b1;
        repeat ($urandom_range(1, 18)) @(negedge clk);
        result_stall <= 1'b0;
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the request was taken,
  // leaving valid high so a back-to-back request needs no second assignment.
  task automatic send_request(input action_t act, input logic reload,
                              input logic [31:0] w, input logic known,
                              input logic [31:0] want);
    if (!calm && gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
      data_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    data_valid  <= 1'b1;
    action      <= act;
    restart     <= reload;
    word_in     <= w;
    known_valid <= known;
    known_word  <= want;
    do @(posedge clk); while (data_stall);
    @(negedge clk);
  endtask

  // The seed may only change with nothing in flight. Every request yields a result, so
  // an empty expectation queue means the pipeline is drained.
  task automatic write_seed(input logic [31:0] value);
    data_valid <= 1'b0;
    while (expected_words.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    seed_wr_en   <= 1'b1;
    seed_wr_data <= value;
    @(negedge clk);
    seed_wr_en <= 1'b0;
  endtask

  function automatic logic [31:0] pick_seed();
    case ($urandom_range(0, 7))
      0: return 32'h0;
      1: return 32'hffff_ffff;
      2: return {KEY_HI_MOD[15:0], KEY_LO_MOD[15:0]};
      3: return {16'($urandom_range(32'hffd9, 32'hffff)),
                 16'($urandom_range(32'hfff1, 32'hffff))};
      4: return {16'h0, 16'($urandom)};
      5: return {16'($urandom), 16'h0};
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 9))
      0: return 32'h0;
      1: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  function automatic int pick_pct();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return 8;
      2: return 25;
      default: return 50;
    endcase
  endfunction

  initial begin
    action_t act;
    logic    reload;

    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part: reset keys, seed halves at zero, at, below and above their moduli,
    // byte order, and back-to-back restarts.
    gap_pct   = 10;
    stall_pct = 10;
    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      if (DIRECTED[i].is_seed) begin
        write_seed(DIRECTED[i].value);
      end else begin
        send_request(DIRECTED[i].act, DIRECTED[i].reload, DIRECTED[i].value,
                     DIRECTED[i].known, DIRECTED[i].want);
      end
    end

    // Random part: each phase writes a new seed and streams words that mostly run on
    // the keystream, with a restart at the start and now and then inside the phase.
    for (int p = 0; p < PHASES; p++) begin
      write_seed(pick_seed());
      calm      = (p == PHASES - 1);
      gap_pct   = calm ? 0 : pick_pct();
      stall_pct = calm ? 0 : pick_pct();
      for (int n = 0; n < PHASE_REQUESTS; n++) begin
        act    = $urandom_range(0, 1) ? ACT_ENCRYPT : ACT_DECRYPT;
        reload = (n == 0) || ($urandom_range(0, 19) == 0);
        send_request(act, reload, pick_word(), 1'b0, 32'h0);
      end
    end

    data_valid <= 1'b0;
    while (expected_words.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run with the longest gaps and stalls.
  initial begin
    #(20_000_000);
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// ----- word_sbox_lehmer_stream_cipher.f -----
+incdir+design
design/wslsc_pkg.sv
design/wslsc_keygen.sv
design/wslsc_xform.sv
design/word_sbox_lehmer_stream_cipher.sv
bench/tb_top.sv
